[src/assert_macros.svh]
// Assertion macros used by the deframer parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define URD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deframer assertion failed");

// Check that a condition never holds outside reset.
`define URD_NEVER(label, cond) \
    `URD_ASSERT(label, !(cond))

`endif

[src/urd_pkg.sv]
// Types and constants for the record deframer.
package urd_pkg;

    localparam int CNT_W    = 5;
    localparam int UUID_W   = 128;
    localparam int INDEX_W  = 16;
    localparam int TDATA_W  = 144;
    localparam int TUSER_W  = 2;
    localparam int S_DATA_W = 8;

    localparam logic [INDEX_W-1:0] INDEX_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_ID  = 2'd0,
        PH_LEN = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic               entry_valid;
        logic [63:0]        uuid_upper;
        logic [63:0]        uuid_lower;
        logic [INDEX_W-1:0] entry_index;
        logic               end_of_buffer;
        logic               malformed;
    } result_t;

endpackage

[src/urd_in_stage.sv]
// Input register stage of the record deframer.
module urd_in_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [urd_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                               s_tlast,
    input  logic                               take,
    output logic                               item_valid,
    output urd_pkg::in_item_t                  item
);
    import urd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

[src/urd_parser.sv]
// Record parser state and per-item result logic.
`include "assert_macros.svh"
module urd_parser #(
    parameter int ID_BYTES  = 16,
    parameter int LEN_BYTES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  urd_pkg::in_item_t item,
    input  logic              out_ready,
    output logic              take,
    output logic              res_valid,
    output urd_pkg::result_t  res
);
    import urd_pkg::*;

    localparam logic [CNT_W-1:0] ID_CNT  = CNT_W'(ID_BYTES);
    localparam logic [CNT_W-1:0] LEN_CNT = CNT_W'(LEN_BYTES);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [UUID_W-1:0]  id_reg;
    logic [UUID_W-1:0]  id_next;
    logic [31:0]        pay_reg;
    logic [31:0]        pay_next;
    logic [INDEX_W-1:0] rec_reg;
    logic [INDEX_W-1:0] rec_next;

    logic [CNT_W-1:0]   cnt_inc;
    logic               id_full;
    logic               len_full;
    logic [31:0]        pay_or;
    logic [31:0]        pay_dec;
    logic [UUID_W-1:0]  id_base;
    logic               done;
    logic               at_rest;

    assign take     = item_valid && out_ready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign id_full  = (cnt_inc >= ID_CNT);
    assign len_full = (cnt_inc >= LEN_CNT);
    assign pay_or   = pay_reg | (32'(item.data_byte) << {cnt_reg[1:0], 3'b000});
    assign pay_dec  = pay_reg - 32'd1;
    assign id_base  = (cnt_reg == '0) ? '0 : id_reg;
    assign at_rest  = (phase_reg == PH_ID) && (cnt_reg == '0) && (rec_reg == '0);

    always_comb
    begin
        case (phase_reg)
            PH_LEN:
            begin
                if (len_full)
                begin
                    phase_next = (pay_or == 32'd0) ? PH_ID : PH_PAY;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_PAY:
            begin
                phase_next = (pay_dec == 32'd0) ? PH_ID : PH_PAY;
            end
            default:
            begin
                phase_next = id_full ? PH_LEN : PH_ID;
            end
        endcase
        if (item.last_byte)
        begin
            phase_next = PH_ID;
        end
    end

    always_comb
    begin
        done     = 1'b0;
        cnt_next = cnt_reg;
        id_next  = id_reg;
        pay_next = pay_reg;
        case (phase_reg)
            PH_LEN:
            begin
                pay_next = pay_or;
                cnt_next = len_full ? '0 : cnt_inc;
                done     = len_full && (pay_or == 32'd0);
            end
            PH_PAY:
            begin
                pay_next = pay_dec;
                done     = (pay_dec == 32'd0);
            end
            default:
            begin
                id_next  = {id_base[UUID_W-9:0], item.data_byte};
                cnt_next = id_full ? '0 : cnt_inc;
                if (id_full)
                begin
                    pay_next = '0;
                end
            end
        endcase

        rec_next = (done && rec_reg != INDEX_MAX) ? rec_reg + INDEX_W'(1) : rec_reg;

        res.entry_valid   = done;
        res.uuid_upper    = done ? id_next[UUID_W-1:64] : '0;
        res.uuid_lower    = done ? id_next[63:0] : '0;
        res.entry_index   = done ? rec_reg : '0;
        res.end_of_buffer = item.last_byte;
        res.malformed     = item.last_byte && !done;
        res_valid         = take && (done || item.last_byte);

        if (item.last_byte)
        begin
            cnt_next = '0;
            id_next  = '0;
            pay_next = '0;
            rec_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            cnt_reg   <= '0;
            id_reg    <= '0;
            pay_reg   <= '0;
            rec_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
            pay_reg   <= pay_next;
            rec_reg   <= rec_next;
        end
    end

    `URD_ASSERT(a_id_cnt_range, (phase_reg == PH_ID) |-> (cnt_reg < ID_CNT))
    `URD_ASSERT(a_len_cnt_range, (phase_reg == PH_LEN) |-> (cnt_reg < LEN_CNT))
    `URD_NEVER(a_pay_nonzero, (phase_reg == PH_PAY) && (pay_reg == 32'd0))
    `URD_ASSERT(a_last_clears, (take && item.last_byte) |=> at_rest)

endmodule

[src/urd_out_stage.sv]
// Result register of the record deframer.
module urd_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    input  urd_pkg::result_t              res,
    output logic                          out_ready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [urd_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tlast,
    output logic [urd_pkg::TUSER_W-1:0]   m_tuser
);
    import urd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {res_reg.entry_index, res_reg.uuid_lower, res_reg.uuid_upper};
    assign m_tlast   = res_reg.end_of_buffer;
    assign m_tuser   = {res_reg.malformed, res_reg.entry_valid};

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid && out_ready)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_ready)
        begin
            res_reg <= res;
        end
    end

endmodule

[src/uuid_record_deframer.sv]
// Top level of the record deframer.
// Usage:
//   s_* channel carries one buffer byte per item; s_tlast marks its final byte.
//   The buffer is a run of records: ID_BYTES identifier bytes, LEN_BYTES
//   little-endian payload length N, then N payload bytes.
//   m_* channel carries zero or one result per byte: one when a record
//   completes (m_tuser[0]) and one on the final byte (m_tlast), with
//   m_tuser[1] set if the buffer stopped inside a record; then drop the run.
// Timing:
//   One item per cycle while m_tready stays high. An accepted byte is
//   loaded into the input register, then carried through the parser into
//   the result register, which drives m_tvalid.
// Reset:
//   rst_n clears both stages and the parser to the identifier phase with
//   record index zero; the parser returns to that state after every final byte.
// Stall:
//   While m_tready is low the result register holds; the input register
//   then fills and s_tready drops until the result is taken.
module uuid_record_deframer #(
    parameter int ID_BYTES  = 16,
    parameter int LEN_BYTES = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [urd_pkg::S_DATA_W-1:0]   s_tdata,   // data_byte[7:0]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [urd_pkg::TDATA_W-1:0]    m_tdata,   // uuid_upper, uuid_lower, entry_index
    output logic                           m_tlast,
    output logic [urd_pkg::TUSER_W-1:0]    m_tuser    // entry_valid, malformed
);
    import urd_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     take;
    logic     out_ready;
    logic     res_valid;
    result_t  res;

    urd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    urd_parser #(
        .ID_BYTES  (ID_BYTES),
        .LEN_BYTES (LEN_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    urd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the record deframer: directed rows and random buffers.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urd_pkg::*;

    localparam int ID_BYTES      = 16;
    localparam int LEN_BYTES     = 4;
    localparam int RANDOM_BYTES  = 1080;
    localparam int TAIL_BYTES    = 200;
    localparam int STALL_LIMIT   = 200;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RESULT = '0;
    localparam result_t CUT_SHORT = '{1'b0, 64'd0, 64'd0, 16'd0, 1'b1, 1'b1};

    localparam stim_row_t DIRECTED [24] = '{
        '{8'hFF, 1'b1, 1'b1, CUT_SHORT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{8'hFE, 1'b0, 1'b0, NO_RESULT},
        '{8'h10, 1'b0, 1'b0, NO_RESULT},
        '{8'h20, 1'b0, 1'b0, NO_RESULT},
        '{8'h30, 1'b0, 1'b0, NO_RESULT},
        '{8'h40, 1'b0, 1'b0, NO_RESULT},
        '{8'h50, 1'b0, 1'b0, NO_RESULT},
        '{8'h60, 1'b0, 1'b0, NO_RESULT},
        '{8'h70, 1'b0, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1,
          '{1'b1, 64'hFF005AA501807FFE, 64'h1020304050607081, 16'd0, 1'b1, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h55, 1'b1, 1'b1, CUT_SHORT}
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic [TUSER_W-1:0]    m_tuser;

    phase_t        rec_phase;
    logic [4:0]    byte_cnt;
    logic [127:0]  id_shift;
    logic [31:0]   pay_left;
    logic [15:0]   rec_count;

    result_t       expected_entries [$];
    bit            idling_on = 1'b1;
    int            stall_left = 0;
    int            idle_cycles = 0;
    int            mismatches = 0;
    int            bytes_sent = 0;
    int            buffers_sent = 0;
    int            random_bytes = 0;
    int            records_checked = 0;
    int            ends_checked = 0;

    uuid_record_deframer #(
        .ID_BYTES  (ID_BYTES),
        .LEN_BYTES (LEN_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_deframe_state();
        rec_phase = PH_ID;
        byte_cnt  = '0;
        id_shift  = '0;
        pay_left  = '0;
        rec_count = '0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic lst,
                                         output logic has_res, output result_t res);
        logic done;
        done = 1'b0;
        res  = '0;
        case (rec_phase)
            PH_LEN:
            begin
                pay_left = pay_left | ({24'd0, b} << (8 * byte_cnt[1:0]));
                byte_cnt = byte_cnt + 5'd1;
                if (byte_cnt >= LEN_BYTES)
                begin
                    byte_cnt = '0;
                    if (pay_left == '0)
                    begin
                        done      = 1'b1;
                        rec_phase = PH_ID;
                    end
                    else
                        rec_phase = PH_PAY;
                end
            end
            PH_PAY:
            begin
                pay_left = pay_left - 32'd1;
                if (pay_left == '0)
                begin
                    done      = 1'b1;
                    rec_phase = PH_ID;
                end
            end
            default:
            begin
                if (byte_cnt == '0)
                    id_shift = '0;
                id_shift  = {id_shift[119:0], b};
                byte_cnt  = byte_cnt + 5'd1;
                rec_phase = PH_ID;
                if (byte_cnt >= ID_BYTES)
                begin
                    byte_cnt  = '0;
                    pay_left  = '0;
                    rec_phase = PH_LEN;
                end
            end
        endcase
        has_res = done | lst;
        if (done)
        begin
            res.entry_valid = 1'b1;
            res.uuid_upper  = id_shift[127:64];
            res.uuid_lower  = id_shift[63:0];
            res.entry_index = rec_count;
        end
        res.end_of_buffer = lst;
        res.malformed     = lst & ~done;
        if (done && rec_count != INDEX_MAX)
            rec_count = rec_count + 16'd1;
        if (lst)
            clear_deframe_state();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic typed, input result_t typed_res);
        logic    has_res;
        result_t res;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deframe_byte(b, lst, has_res, res);
        if (typed)
        begin
            has_res = 1'b1;
            res     = typed_res;
        end
        if (has_res)
            expected_entries.push_back(res);
        bytes_sent++;
        if (lst)
            buffers_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_buffer();
        logic [7:0]  bytes_q [$];
        int unsigned n_rec;
        int unsigned len;
        int unsigned n_pay;
        bit          broken;
        n_pay = 0;
        if ($urandom_range(0, 19) == 0)
            bytes_q.push_back(8'($urandom));
        else
        begin
            broken = ($urandom_range(0, 4) == 0);
            n_rec  = $urandom_range(1, 4);
            for (int r = 0; r < n_rec; r++)
            begin
                for (int i = 0; i < ID_BYTES; i++)
                    bytes_q.push_back(8'($urandom));
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = $urandom_range(9, 300);
                    default: len = $urandom_range(1, 8);
                endcase
                n_pay = len;
                if (broken && r == n_rec - 1)
                begin
                    len = $urandom;
                    if (len < 4)
                        len = 4;
                    n_pay = $urandom_range(0, 3);
                end
                for (int i = 0; i < LEN_BYTES; i++)
                    bytes_q.push_back(8'(len >> (8 * i)));
                for (int i = 0; i < n_pay; i++)
                    bytes_q.push_back(8'($urandom));
            end
            if (broken)
                repeat ($urandom_range(0, ID_BYTES + LEN_BYTES + n_pay - 1))
                    void'(bytes_q.pop_back());
        end
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, NO_RESULT);
        random_bytes += bytes_q.size();
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        mismatches++;
        $display("%0t ns: %s expected %h got %h", $time, field, want_v, got_v);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser[0], m_tdata[63:0], m_tdata[127:64], m_tdata[143:128],
                    m_tlast, m_tuser[1]};
            if (expected_entries.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with none expected: expected nothing got %h",
                         $time, got);
            end
            else
            begin
                want = expected_entries.pop_front();
                if (got.entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
                if (got.uuid_upper !== want.uuid_upper)
                    report_mismatch("uuid_upper", want.uuid_upper, got.uuid_upper);
                if (got.uuid_lower !== want.uuid_lower)
                    report_mismatch("uuid_lower", want.uuid_lower, got.uuid_lower);
                if (got.entry_index !== want.entry_index)
                    report_mismatch("entry_index", 64'(want.entry_index), 64'(got.entry_index));
                if (got.end_of_buffer !== want.end_of_buffer)
                    report_mismatch("end_of_buffer", 64'(want.end_of_buffer),
                                    64'(got.end_of_buffer));
                if (got.malformed !== want.malformed)
                    report_mismatch("malformed", 64'(want.malformed), 64'(got.malformed));
            end
            if (got.entry_valid === 1'b1)
                records_checked++;
            if (got.end_of_buffer === 1'b1)
                ends_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no item moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_entries.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_deframe_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
        while (random_bytes < RANDOM_BYTES - TAIL_BYTES)
            send_random_buffer();
        idling_on = 1'b0;
        while (random_bytes < RANDOM_BYTES)
            send_random_buffer();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d buffers, the last stretch with no gaps on either side.",
                 bytes_sent, buffers_sent);
        $display("Checked %0d completed records and %0d buffer ends, %0d mismatches.",
                 records_checked, ends_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
